// File: rtl/mask_pair_set_canonicalizer_defines.svh
// Assertion macros shared by the RTL of the mask pair set canonicaliser.
// Needs a clk and an rst_n in scope at the point of use.
`ifndef MASK_PAIR_SET_CANONICALIZER_DEFINES_SVH
`define MASK_PAIR_SET_CANONICALIZER_DEFINES_SVH

// same-cycle implication
`define MPSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpsc check failed");

// next-cycle implication
`define MPSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpsc check failed");

`endif

// File: rtl/mpsc_pkg.sv
// Shared types and constants of the mask pair set canonicaliser.
// No dependencies.
package mpsc_pkg;

    localparam int WORD_W    = 16;
    localparam int NUM_WORDS = 8;
    localparam int PERM_W    = 3;
    localparam int CNT_W     = 4;
    localparam logic [CNT_W-1:0] COL_RESET = 4'd4;
    localparam logic [WORD_W-1:0] PAD_WORD = 16'hFFFF;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_LAST = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic last_pair;
    } status_t;

endpackage

// File: rtl/mpsc_in_if.sv
// Input channel of the canonicaliser: valid/ready and eight words.
// Depends on mpsc_pkg.
interface mpsc_in_if;
    logic            valid;
    logic            ready;
    mpsc_pkg::word_t word_0;
    mpsc_pkg::word_t word_1;
    mpsc_pkg::word_t word_2;
    mpsc_pkg::word_t word_3;
    mpsc_pkg::word_t word_4;
    mpsc_pkg::word_t word_5;
    mpsc_pkg::word_t word_6;
    mpsc_pkg::word_t word_7;

    modport source (output valid, word_0, word_1, word_2, word_3,
                    word_4, word_5, word_6, word_7, input ready);
    modport sink   (input valid, word_0, word_1, word_2, word_3,
                    word_4, word_5, word_6, word_7, output ready);
endinterface

// File: rtl/mpsc_out_if.sv
// Output channel of the canonicaliser: valid/ready and eight words.
// Depends on mpsc_pkg.
interface mpsc_out_if;
    logic            valid;
    logic            ready;
    mpsc_pkg::word_t canon_0;
    mpsc_pkg::word_t canon_1;
    mpsc_pkg::word_t canon_2;
    mpsc_pkg::word_t canon_3;
    mpsc_pkg::word_t canon_4;
    mpsc_pkg::word_t canon_5;
    mpsc_pkg::word_t canon_6;
    mpsc_pkg::word_t canon_7;

    modport source (output valid, canon_0, canon_1, canon_2, canon_3,
                    canon_4, canon_5, canon_6, canon_7, input ready);
    modport sink   (input valid, canon_0, canon_1, canon_2, canon_3,
                    canon_4, canon_5, canon_6, canon_7, output ready);
endinterface

// File: rtl/mask_pair_set_canonicalizer.sv
// Mask pair set canonicaliser: top level joining controller and datapath.
// Depends on mpsc_pkg, mpsc_in_if, mpsc_out_if, mpsc_ctrl, mpsc_datapath.
//
// Use:
//   in_ch carries one item: eight 16-bit words, each an X column mask in
//   the low C bits and a Y column mask in the next C bits. out_ch returns
//   the canonical set: the smallest, in word-by-word order, of all sorted
//   sets obtained by independent X and Y column permutations. Words at or
//   beyond C read zero.
//   cfg_we/cfg_wdata write the column count C (1..8, saturated to
//   MAX_COLUMNS); write it only while the block is idle. Reset value 4.
// Timing:
//   One permutation pair is tried per cycle, so an item goes through load,
//   a search over all C!*C! pairs, a final compare and output.
//   The X and Y permutation steppers and the single sort unit set this rate.
//   One item is in flight at a time; in_ch.ready is high only while idle.
// Reset:
//   rst_n clears the controller to idle, the column count to 4 and the
//   permutations to identity; no result is pending.
// Stall:
//   The result is held in the best-set register with out_ch.valid high
//   until out_ch.ready; no new item is taken until then.
module mask_pair_set_canonicalizer #(
    parameter int MAX_COLUMNS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [mpsc_pkg::CNT_W-1:0] cfg_wdata,
    mpsc_in_if.sink                    in_ch,
    mpsc_out_if.source                 out_ch
);

    mpsc_pkg::cmd_t    cmd;
    mpsc_pkg::status_t status;
    mpsc_pkg::word_t   in_words  [mpsc_pkg::NUM_WORDS];
    mpsc_pkg::word_t   out_words [mpsc_pkg::NUM_WORDS];

    assign in_words[0] = in_ch.word_0;
    assign in_words[1] = in_ch.word_1;
    assign in_words[2] = in_ch.word_2;
    assign in_words[3] = in_ch.word_3;
    assign in_words[4] = in_ch.word_4;
    assign in_words[5] = in_ch.word_5;
    assign in_words[6] = in_ch.word_6;
    assign in_words[7] = in_ch.word_7;

    assign out_ch.canon_0 = out_words[0];
    assign out_ch.canon_1 = out_words[1];
    assign out_ch.canon_2 = out_words[2];
    assign out_ch.canon_3 = out_words[3];
    assign out_ch.canon_4 = out_words[4];
    assign out_ch.canon_5 = out_words[5];
    assign out_ch.canon_6 = out_words[6];
    assign out_ch.canon_7 = out_words[7];

    mpsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mpsc_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .in_words  (in_words),
        .out_words (out_words)
    );

endmodule

// File: rtl/mpsc_ctrl.sv
// Controller of the canonicaliser: sequences one item through the search.
// Depends on mpsc_pkg and the defines header.
`include "mask_pair_set_canonicalizer_defines.svh"

module mpsc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  mpsc_pkg::status_t  status,
    output mpsc_pkg::cmd_t     cmd
);

    mpsc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpsc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            mpsc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = mpsc_pkg::ST_RUN;
                end
            end
            mpsc_pkg::ST_RUN:
            begin
                cmd.step = 1'b1;
                if (status.last_pair)
                begin
                    state_next = mpsc_pkg::ST_LAST;
                end
            end
            mpsc_pkg::ST_LAST:
            begin
                state_next = mpsc_pkg::ST_OUT;
            end
            mpsc_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = mpsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpsc_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == mpsc_pkg::ST_IDLE);
    assign out_valid = (state_reg == mpsc_pkg::ST_OUT);

    `MPSC_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
    `MPSC_ASSERT_NEXT(a_start_runs, cmd.start, cmd.step)
    `MPSC_ASSERT_NEXT(a_last_flush, cmd.step && status.last_pair, !cmd.step && !out_valid)
    `MPSC_ASSERT_NOW(a_step_busy, cmd.step, !in_ready)

endmodule

// File: rtl/mpsc_datapath.sv
// Datapath of the canonicaliser: permutation stepping, sort, best-set keep.
// Depends on mpsc_pkg.
module mpsc_datapath #(
    parameter int MAX_COLUMNS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpsc_pkg::CNT_W-1:0]    cfg_wdata,
    input  mpsc_pkg::cmd_t                cmd,
    output mpsc_pkg::status_t             status,
    input  mpsc_pkg::word_t               in_words [mpsc_pkg::NUM_WORDS],
    output mpsc_pkg::word_t               out_words [mpsc_pkg::NUM_WORDS]
);

    localparam int IDX_W = $clog2(MAX_COLUMNS);
    localparam int NW    = mpsc_pkg::NUM_WORDS;
    localparam logic [mpsc_pkg::CNT_W-1:0] MAX_CNT = mpsc_pkg::CNT_W'(MAX_COLUMNS);

    typedef logic [MAX_COLUMNS-1:0][mpsc_pkg::PERM_W-1:0] perm_vec_t;

    logic [mpsc_pkg::CNT_W-1:0] col_count_reg;
    logic [mpsc_pkg::CNT_W-1:0] n_reg;
    mpsc_pkg::word_t            words_reg [NW];
    perm_vec_t                  px_reg, py_reg, px_next, py_next;
    logic                       x_wrap, y_wrap;
    mpsc_pkg::word_t            cand_reg [NW];
    logic                       cand_v_reg;
    mpsc_pkg::word_t            best_reg [NW];
    logic                       best_valid_reg;
    mpsc_pkg::word_t            sorted [NW];
    logic                       less;

    function automatic perm_vec_t next_perm(input perm_vec_t p,
                                            input logic [mpsc_pkg::CNT_W-1:0] n,
                                            output logic wrap);
        perm_vec_t        r;
        logic             found;
        logic [IDX_W-1:0] piv;
        logic [IDX_W-1:0] jj;
        int               m;
        found = 1'b0;
        piv   = '0;
        jj    = '0;
        r     = p;
        for (int i = 0; i < MAX_COLUMNS - 1; i++)
        begin
            if ((i + 1 < int'(n)) && (p[i] < p[i+1]))
            begin
                found = 1'b1;
                piv   = IDX_W'(i);
            end
        end
        for (int k = 0; k < MAX_COLUMNS; k++)
        begin
            if ((k < int'(n)) && (k > int'(piv)) && (p[k] > p[piv]))
            begin
                jj = IDX_W'(k);
            end
        end
        if (found)
        begin
            for (int k = 0; k < MAX_COLUMNS; k++)
            begin
                if ((k > int'(piv)) && (k < int'(n)))
                begin
                    m = int'(n) + int'(piv) - k;
                    r[k] = (IDX_W'(m) == jj) ? p[piv] : p[IDX_W'(m)];
                end
            end
            r[piv] = p[jj];
        end
        else
        begin
            for (int k = 0; k < MAX_COLUMNS; k++)
            begin
                r[k] = mpsc_pkg::PERM_W'(k);
            end
        end
        wrap = !found;
        return r;
    endfunction

    always_comb
    begin
        px_next = next_perm(px_reg, n_reg, x_wrap);
        py_next = next_perm(py_reg, n_reg, y_wrap);
    end

    assign status.last_pair = x_wrap && y_wrap;

    // candidate words then odd-even transposition sort
    always_comb
    begin
        mpsc_pkg::word_t v [NW];
        mpsc_pkg::word_t t;
        logic [3:0]      pos;
        t   = '0;
        pos = '0;
        for (int k = 0; k < NW; k++)
        begin
            v[k] = mpsc_pkg::PAD_WORD;
            if (k < int'(n_reg) && k < MAX_COLUMNS)
            begin
                v[k] = '0;
                for (int i = 0; i < MAX_COLUMNS; i++)
                begin
                    if (i < int'(n_reg))
                    begin
                        if (words_reg[k][i])
                        begin
                            v[k][{1'b0, px_reg[i]}] = 1'b1;
                        end
                        pos = n_reg + 4'(i);
                        if (words_reg[k][pos])
                        begin
                            pos = n_reg + {1'b0, py_reg[i]};
                            v[k][pos] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int s = 0; s < NW; s++)
        begin
            for (int k = (s % 2); k + 1 < NW; k += 2)
            begin
                if (v[k] > v[k+1])
                begin
                    t      = v[k];
                    v[k]   = v[k+1];
                    v[k+1] = t;
                end
            end
        end
        for (int k = 0; k < NW; k++)
        begin
            sorted[k] = v[k];
        end
    end

    // word-by-word compare, lowest differing word decides
    always_comb
    begin
        less = 1'b0;
        for (int k = NW - 1; k >= 0; k--)
        begin
            if (cand_reg[k] != best_reg[k])
            begin
                less = cand_reg[k] < best_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg  <= mpsc_pkg::COL_RESET;
            n_reg          <= mpsc_pkg::COL_RESET;
            cand_v_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_COLUMNS; k++)
            begin
                px_reg[k] <= mpsc_pkg::PERM_W'(k);
                py_reg[k] <= mpsc_pkg::PERM_W'(k);
            end
        end
        else
        begin
            if (cfg_we)
            begin
                col_count_reg <= cfg_wdata;
            end
            cand_v_reg <= cmd.step;
            if (cmd.start)
            begin
                n_reg          <= (col_count_reg > MAX_CNT) ? MAX_CNT : col_count_reg;
                best_valid_reg <= 1'b0;
                for (int k = 0; k < MAX_COLUMNS; k++)
                begin
                    px_reg[k] <= mpsc_pkg::PERM_W'(k);
                    py_reg[k] <= mpsc_pkg::PERM_W'(k);
                end
            end
            else if (cmd.step)
            begin
                px_reg <= px_next;
                if (x_wrap)
                begin
                    py_reg <= py_next;
                end
            end
            if (cand_v_reg && (!best_valid_reg || less))
            begin
                best_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            words_reg <= in_words;
        end
        if (cmd.step)
        begin
            cand_reg <= sorted;
        end
        if (cand_v_reg && (!best_valid_reg || less))
        begin
            best_reg <= cand_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < NW; k++)
        begin
            out_words[k] = (k < int'(n_reg)) ? best_reg[k] : '0;
        end
    end

endmodule
